[rtl/dlt_pkg.sv]
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared types, codes and saturation helpers for the dense layer trainer.
// ----------------------------------------------------------------------------
package dlt_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_ELEM = 2'd0;
    localparam logic [1:0] KIND_LOSS = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    // Result kinds
    localparam logic RK_NET  = 1'b0;
    localparam logic RK_LOSS = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_INPUTS  = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_OUTPUTS = 2'd1;
    localparam logic [1:0] CFG_LEARNING_RATE  = 2'd2;

    // Classified operations handed from front to back
    typedef enum logic [1:0] {
        OP_ELEM = 2'd0,
        OP_LOSS = 2'd1,
        OP_LOAD = 2'd2
    } t_op;

    // One queued request; flag marks the run trigger (ELEM) or last node (LOSS)
    typedef struct packed {
        t_op                op;
        logic               flag;
        logic [5:0]         ch;
        logic [5:0]         nd;
        logic signed [15:0] value;
        logic signed [15:0] theta;
    } t_cmd;

    // Back-end status seen by the front and the top level
    typedef struct packed {
        logic clearing;
        logic idle;
    } t_status;

    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd32767) r = 16'sh7fff;
        else if (v < -25'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7fff_ffff) r = 32'sh7fff_ffff;
        else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

[rtl/dlt_front.sv]
// ----------------------------------------------------------------------------
// dlt_front
// Accepts input requests, classifies and filters them, and queues them for
// the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module dlt_front #(
    parameter int MAX_INPUTS = 64,
    parameter int MAX_NODES  = 64,
    parameter int CIW        = 7,
    parameter int CNW        = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_kind,
    input  logic [5:0]          i_channel,
    input  logic [5:0]          i_node,
    input  logic signed [15:0]  i_value,
    input  logic signed [15:0]  i_theta,
    input  logic [CIW-1:0]      i_ni,
    input  logic [CNW-1:0]      i_no,
    input  dlt_pkg::t_status    i_status,
    output dlt_pkg::t_cmd       o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop
);
    import dlt_pkg::*;

    t_cmd       r_q [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_keep, w_push, w_pop;

    // Classify the request and drop the ones that do nothing
    always_comb begin
        w_cmd.ch    = i_channel;
        w_cmd.nd    = i_node;
        w_cmd.value = i_value;
        w_cmd.theta = i_theta;
        w_cmd.op    = OP_ELEM;
        w_cmd.flag  = 1'b0;
        w_keep      = 1'b0;
        case (i_kind)
            KIND_ELEM: begin
                w_cmd.op   = OP_ELEM;
                w_cmd.flag = (32'(i_channel) == 32'(i_ni) - 1);
                w_keep     = (32'(i_channel) < MAX_INPUTS);
            end
            KIND_LOSS: begin
                w_cmd.op   = OP_LOSS;
                w_cmd.flag = (32'(i_node) == 32'(i_no) - 1);
                w_keep     = (32'(i_node) < 32'(i_no));
            end
            KIND_LOAD: begin
                w_cmd.op = OP_LOAD;
                w_keep   = (32'(i_channel) < MAX_INPUTS) && (32'(i_node) < MAX_NODES);
            end
            default: w_keep = 1'b0;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2) && !i_status.clearing;
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_pop;
    assign o_cmd       = r_q[r_rp];

    // Store queued requests
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/dlt_back.sv]
// ----------------------------------------------------------------------------
// dlt_back
// Carries out queued requests: owns the input, weight, theta and accumulator
// memories, walks forward and backward passes and drives the result register.
// ----------------------------------------------------------------------------
module dlt_back #(
    parameter int MAX_INPUTS = 64,
    parameter int MAX_NODES  = 64,
    parameter int CIW        = 7,
    parameter int CNW        = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlt_pkg::t_cmd       i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  logic [CIW-1:0]      i_ni,
    input  logic [CNW-1:0]      i_no,
    input  logic [14:0]         i_rate,
    output dlt_pkg::t_status    o_status,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic [5:0]          o_index,
    output logic signed [31:0]  o_value,
    output logic                o_last
);
    import dlt_pkg::*;

    localparam int WD  = MAX_NODES * MAX_INPUTS;
    localparam int AW  = (WD > 1) ? $clog2(WD) : 1;
    localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [IW-1:0] IMAX = IW'(MAX_INPUTS - 1);
    localparam logic [AW-1:0] AMAX = AW'(WD - 1);

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_FW_RD   = 16'h0004,
        S_FW_MUL  = 16'h0008,
        S_FW_ACC  = 16'h0010,
        S_FW_EMIT = 16'h0020,
        S_BW_TH   = 16'h0040,
        S_BW_RD   = 16'h0080,
        S_BW_M1   = 16'h0100,
        S_BW_M2   = 16'h0200,
        S_BW_WR   = 16'h0400,
        S_EM_RD   = 16'h0800,
        S_EM_LD   = 16'h1000,
        S_EM_DIV  = 16'h2000,
        S_EM_OUT  = 16'h4000,
        S_EM_CLR  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    // Memories
    logic signed [15:0] x_mem [0:MAX_INPUTS-1];
    logic signed [15:0] w_mem [0:WD-1];
    logic signed [15:0] t_mem [0:WD-1];
    logic signed [31:0] a_mem [0:MAX_INPUTS-1];

    logic signed [15:0] r_xq, r_wq, r_tq;
    logic signed [31:0] r_aq;

    // Sequencer registers
    logic [AW-1:0]      r_clr;
    logic [IW-1:0]      r_i;
    logic [NIW-1:0]     r_n;
    logic [AW-1:0]      r_base;
    logic signed [47:0] r_net;
    logic signed [31:0] r_prod;
    logic signed [15:0] r_loss;
    logic               r_node_last;
    logic signed [19:0] r_dth;
    logic signed [19:0] r_nl;
    logic signed [23:0] r_p;
    logic [31:0]        r_dvd;
    logic [CIW-1:0]     r_rem;
    logic [4:0]         r_cnt;
    logic               r_neg;

    // Result register
    logic               r_o_valid;
    logic               r_o_kind;
    logic [5:0]         r_o_index;
    logic signed [31:0] r_o_value;
    logic               r_o_last;

    // Write ports
    logic               x_we, w_we, a_we;
    logic [IW-1:0]      x_wa, a_wa;
    logic [AW-1:0]      w_wa;
    logic signed [15:0] x_wd, w_wd, t_wd;
    logic signed [31:0] a_wd;
    logic [AW-1:0]      w_ra;

    logic [IW-1:0]      w_ni_last;
    logic [NIW-1:0]     w_no_last;
    logic               w_emit_ok, w_take, w_o_load;
    logic signed [15:0] w_rate_s;
    logic signed [31:0] w_xw, w_lr, w_lx;
    logic signed [35:0] w_np;
    logic [CIW:0]       w_trial;
    logic               w_ge;
    logic [32:0]        w_negacc;
    logic [31:0]        w_mag;
    logic signed [33:0] w_q;
    logic signed [31:0] w_fw_out, w_em_out;
    logic               w_clr_small;

    assign w_ni_last   = IW'(i_ni - CIW'(1));
    assign w_no_last   = NIW'(i_no - CNW'(1));
    assign w_emit_ok   = !r_o_valid || i_ready;
    assign w_o_load    = w_emit_ok && ((r_state == S_FW_EMIT) || (r_state == S_EM_OUT));
    assign w_take      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop   = w_take;
    assign w_ra        = r_base + AW'(r_i);
    assign w_rate_s    = $signed({1'b0, i_rate});
    assign w_xw        = r_xq * r_wq;
    assign w_lr        = r_loss * w_rate_s;
    assign w_lx        = r_loss * r_xq;
    assign w_np        = 36'(r_nl) * 36'(w_rate_s);
    assign w_trial     = {r_rem, r_dvd[31]};
    assign w_ge        = (w_trial >= {1'b0, i_ni});
    assign w_negacc    = -{r_aq[31], r_aq};
    assign w_mag       = r_aq[31] ? w_negacc[31:0] : r_aq;
    assign w_q         = r_neg ? -$signed({2'b00, r_dvd}) : $signed({2'b00, r_dvd});
    assign w_fw_out    = sat32(r_net);
    assign w_em_out    = sat32(48'(r_aq) + 48'(w_q));
    assign w_clr_small = ({1'b0, r_clr} < (AW + 1)'(MAX_INPUTS));

    // Select memory writes
    always_comb begin
        x_we = 1'b0; x_wa = IW'(i_cmd.ch); x_wd = i_cmd.value;
        w_we = 1'b0; w_wa = w_ra;          w_wd = i_cmd.value; t_wd = i_cmd.theta;
        a_we = 1'b0; a_wa = r_i;           a_wd = '0;
        case (r_state)
            S_CLEAR: begin
                x_we = w_clr_small; x_wa = r_clr[IW-1:0]; x_wd = '0;
                w_we = 1'b1;        w_wa = r_clr;         w_wd = '0; t_wd = '0;
                a_we = w_clr_small; a_wa = r_clr[IW-1:0];
            end
            S_IDLE: begin
                x_we = w_take && (i_cmd.op == OP_ELEM);
                w_we = w_take && (i_cmd.op == OP_LOAD);
                w_wa = AW'(32'(i_cmd.nd) * MAX_INPUTS + 32'(i_cmd.ch));
            end
            S_BW_WR: begin
                w_we = 1'b1;
                w_wd = sat16(25'(r_wq) + 25'(r_p));
                t_wd = sat16(25'(r_tq) + 25'(r_dth));
                a_we = 1'b1;
                a_wd = sat32(48'(r_aq) + 48'(r_nl));
            end
            S_EM_OUT: a_we = w_emit_ok;
            S_EM_CLR: a_we = 1'b1;
            default: ;
        endcase
    end

    // Memory ports: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (x_we) x_mem[x_wa] <= x_wd;
        if (w_we) begin
            w_mem[w_wa] <= w_wd;
            t_mem[w_wa] <= t_wd;
        end
        if (a_we) a_mem[a_wa] <= a_wd;
        r_xq <= x_mem[r_i];
        r_wq <= w_mem[w_ra];
        r_tq <= t_mem[w_ra];
        r_aq <= a_mem[r_i];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (r_clr == AMAX) n_state = S_IDLE;
            S_IDLE: begin
                if (w_take) begin
                    if (i_cmd.op == OP_ELEM && i_cmd.flag) n_state = S_FW_RD;
                    else if (i_cmd.op == OP_LOSS)          n_state = S_BW_TH;
                end
            end
            S_FW_RD:   n_state = S_FW_MUL;
            S_FW_MUL:  n_state = S_FW_ACC;
            S_FW_ACC:  n_state = (r_i == w_ni_last) ? S_FW_EMIT : S_FW_RD;
            S_FW_EMIT: if (w_emit_ok) n_state = (r_n == w_no_last) ? S_IDLE : S_FW_RD;
            S_BW_TH:   n_state = S_BW_RD;
            S_BW_RD:   n_state = S_BW_M1;
            S_BW_M1:   n_state = S_BW_M2;
            S_BW_M2:   n_state = S_BW_WR;
            S_BW_WR: begin
                if (r_i != w_ni_last) n_state = S_BW_RD;
                else                  n_state = r_node_last ? S_EM_RD : S_IDLE;
            end
            S_EM_RD:   n_state = S_EM_LD;
            S_EM_LD:   n_state = S_EM_DIV;
            S_EM_DIV:  if (r_cnt == 5'd31) n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (w_emit_ok) begin
                    if (r_i != w_ni_last) n_state = S_EM_RD;
                    else n_state = (r_i == IMAX) ? S_IDLE : S_EM_CLR;
                end
            end
            S_EM_CLR:  if (r_i == IMAX) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_i       <= '0;
            r_n       <= '0;
            r_base    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Load a new result, or drop the one taken downstream
            if (w_o_load)     r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + AW'(1);
                S_IDLE: begin
                    r_i <= '0;
                    r_n <= '0;
                    r_net <= '0;
                    if (w_take) begin
                        r_loss      <= i_cmd.value;
                        r_node_last <= i_cmd.flag;
                        r_base      <= (i_cmd.op == OP_LOSS) ?
                                       AW'(32'(i_cmd.nd) * MAX_INPUTS) : '0;
                    end
                end
                S_FW_MUL: r_prod <= w_xw;
                S_FW_ACC: begin
                    r_net <= r_net + 48'(r_prod >>> 12) + 48'(r_tq);
                    if (r_i != w_ni_last) r_i <= r_i + IW'(1);
                end
                S_FW_EMIT: begin
                    if (w_emit_ok) begin
                        r_o_kind  <= RK_NET;
                        r_o_index <= 6'(r_n);
                        r_o_value <= w_fw_out;
                        r_o_last  <= (r_n == w_no_last);
                        r_net     <= '0;
                        r_i       <= '0;
                        r_n       <= r_n + NIW'(1);
                        r_base    <= r_base + AW'(MAX_INPUTS);
                    end
                end
                S_BW_TH: r_dth <= 20'(w_lr >>> 12);
                S_BW_M1: r_nl  <= 20'(w_lx >>> 12);
                S_BW_M2: r_p   <= 24'(w_np >>> 12);
                S_BW_WR: begin
                    if (r_i != w_ni_last) r_i <= r_i + IW'(1);
                    else                  r_i <= '0;
                end
                S_EM_LD: begin
                    r_dvd <= w_mag;
                    r_neg <= r_aq[31];
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                S_EM_DIV: begin
                    r_rem <= w_ge ? CIW'(w_trial - {1'b0, i_ni}) : CIW'(w_trial);
                    r_dvd <= {r_dvd[30:0], w_ge};
                    r_cnt <= r_cnt + 5'd1;
                end
                S_EM_OUT: begin
                    if (w_emit_ok) begin
                        r_o_kind  <= RK_LOSS;
                        r_o_index <= 6'(r_i);
                        r_o_value <= w_em_out;
                        r_o_last  <= (r_i == w_ni_last);
                        if (r_i != IMAX) r_i <= r_i + IW'(1);
                    end
                end
                S_EM_CLR: if (r_i != IMAX) r_i <= r_i + IW'(1);
                default: ;
            endcase
        end
    end

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_status.idle     = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_kind  = r_o_kind;
    assign o_index = r_o_index;
    assign o_value = r_o_value;
    assign o_last  = r_o_last;

endmodule

[rtl/dense_layer_delta_rule_trainer_core.sv]
// ----------------------------------------------------------------------------
// dense_layer_delta_rule_trainer_core
// Fully connected perceptron layer with delta-rule training in Q4.12.
// ----------------------------------------------------------------------------
// After reset the block sweeps its weight and theta memories to zero; no
// request is taken during that sweep, though configuration writes are.
// Loads and ordinary input elements are written to memory straight from
// the idle state. The element for the last active channel starts a forward
// walk (read, multiply, accumulate per active input, then emit per active
// node), carried out on the single shared multiply-accumulate path with the
// one read port per memory. A loss request works out the theta step, then
// reads, multiplies twice and writes back per input; the loss of the last
// active node then runs the bit-serial divider for each active input and
// clears each remaining accumulator. A two-entry queue lets requests be
// taken while the back end is busy, and results wait in an output register.
module dense_layer_delta_rule_trainer_core #(
    parameter int MAX_INPUTS = 64,
    parameter int MAX_NODES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // channel[5:0], node[11:6], value[27:12], theta_value[43:28]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // index[5:0], result_value[37:6]
    output logic [0:0]  o_m_tuser,   // result_kind[0]
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);
    import dlt_pkg::*;

    localparam int CIW = $clog2(MAX_INPUTS + 1);
    localparam int CNW = $clog2(MAX_NODES + 1);

    logic [6:0]     r_act_in, r_act_out;
    logic [14:0]    r_rate;
    logic [CIW-1:0] w_ni;
    logic [CNW-1:0] w_no;
    t_cmd           w_cmd;
    logic           w_cmd_valid, w_cmd_pop;
    t_status        w_status;
    logic           w_kind;
    logic [5:0]     w_index;
    logic signed [31:0] w_value;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_in  <= 7'd64;
            r_act_out <= 7'd64;
            r_rate    <= 15'd409;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_INPUTS:  r_act_in  <= i_cfg_data[6:0];
                CFG_ACTIVE_OUTPUTS: r_act_out <= i_cfg_data[6:0];
                CFG_LEARNING_RATE:  r_rate    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp active counts to the storage, raising zero to one
    always_comb begin
        if (r_act_in == 7'd0)                w_ni = CIW'(1);
        else if (32'(r_act_in) > MAX_INPUTS) w_ni = CIW'(MAX_INPUTS);
        else                                 w_ni = CIW'(r_act_in);
        if (r_act_out == 7'd0)               w_no = CNW'(1);
        else if (32'(r_act_out) > MAX_NODES) w_no = CNW'(MAX_NODES);
        else                                 w_no = CNW'(r_act_out);
    end

    dlt_front #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_NODES  (MAX_NODES),
        .CIW        (CIW),
        .CNW        (CNW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_kind      (i_s_tuser),
        .i_channel   (i_s_tdata[5:0]),
        .i_node      (i_s_tdata[11:6]),
        .i_value     (i_s_tdata[27:12]),
        .i_theta     (i_s_tdata[43:28]),
        .i_ni        (w_ni),
        .i_no        (w_no),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    dlt_back #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_NODES  (MAX_NODES),
        .CIW        (CIW),
        .CNW        (CNW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_ni        (w_ni),
        .i_no        (w_no),
        .i_rate      (r_rate),
        .o_status    (w_status),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (w_kind),
        .o_index     (w_index),
        .o_value     (w_value),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_value, w_index};
    assign o_m_tuser = w_kind;

    // No request is taken during the clearing sweep
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !o_s_tready)
        else $error("request taken during clearing sweep");

    // No result appears during the clearing sweep
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !o_m_tvalid)
        else $error("result shown during clearing sweep");

    // The back end only pulls from the queue while idle
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_status.idle && w_cmd_valid))
        else $error("queue popped outside idle");

endmodule
